// ===== rtl/core/base64_stream_encoder_core_macros.svh =====
// assertion macros for the base64 stream encoder core
`ifndef BASE64_STREAM_ENCODER_CORE_MACROS_SVH
`define BASE64_STREAM_ENCODER_CORE_MACROS_SVH

// checked only outside reset
`define B64SE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define B64SE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/b64se_pkg.sv =====
// shared types, constants and character mapping for the base64 stream encoder
package b64se_pkg;

  localparam int B64SE_QUEUE_DEPTH = 2;

  localparam logic [7:0] PAD_CHAR    = 8'h3d;
  localparam logic [7:0] UPPER_BASE  = 8'h41;
  localparam logic [7:0] LOWER_OFFS  = 8'd71;
  localparam logic [7:0] DIGIT_OFFS  = 8'd4;
  localparam logic [7:0] PLUS_CHAR   = 8'h2b;
  localparam logic [7:0] SLASH_CHAR  = 8'h2f;
  localparam logic [5:0] LOWER_START = 6'd26;
  localparam logic [5:0] DIGIT_START = 6'd52;
  localparam logic [5:0] PLUS_CODE   = 6'd62;

  localparam logic [1:0] CNT_EMPTY = 2'd0;
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;
  localparam logic [1:0] LAST_CHAR = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_end;
    logic       message_end;
  } out_item_t;

  // one group ready for character generation
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  held;
    logic        fin;
  } group_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] ext;
    ext = {2'b00, v};
    if (v < LOWER_START) begin
      return UPPER_BASE + ext;
    end else if (v < DIGIT_START) begin
      return ext + LOWER_OFFS;
    end else if (v < PLUS_CODE) begin
      return ext - DIGIT_OFFS;
    end else if (v == PLUS_CODE) begin
      return PLUS_CHAR;
    end else begin
      return SLASH_CHAR;
    end
  endfunction

endpackage

// ===== rtl/core/b64se_front.sv =====
// front end: takes bytes, gathers three-byte groups, hands finished groups to the queue
module b64se_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  b64se_pkg::in_item_t byte_item,
  input  logic               queue_full,
  output logic               push,
  output b64se_pkg::group_t  group
);
  import b64se_pkg::*;

  logic [1:0]  cnt;
  logic [15:0] held;
  logic [1:0]  cnt_eff;
  logic        accept;
  logic        complete;

  always_comb begin
    cnt_eff    = (cnt == LAST_CHAR) ? CNT_EMPTY : cnt;
    byte_stall = queue_full;
    accept     = byte_valid && !queue_full;
    complete   = (cnt_eff == CNT_TWO) || byte_item.is_final;
    push       = accept && complete;
    group.held = cnt_eff;
    group.fin  = byte_item.is_final;
    case (cnt_eff)
      CNT_TWO: group.word = {held, byte_item.data_byte};
      CNT_ONE: group.word = {held[7:0], byte_item.data_byte, 8'h00};
      default: group.word = {byte_item.data_byte, 16'h0000};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= CNT_EMPTY;
      held <= 16'h0000;
    end else if (accept) begin
      if (complete) begin
        cnt  <= CNT_EMPTY;
        held <= 16'h0000;
      end else begin
        cnt  <= cnt_eff + CNT_ONE;
        held <= {held[7:0], byte_item.data_byte};
      end
    end
  end

endmodule

// ===== rtl/core/b64se_queue.sv =====
// short group queue between front and back
module b64se_queue #(
  parameter int Depth = b64se_pkg::B64SE_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64se_pkg::group_t push_group,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output b64se_pkg::group_t head_group
);
  import b64se_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  group_t          slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  always_comb begin
    full       = (count == CntFull);
    head_valid = (count != '0);
    head_group = slots[rd_ptr];
    do_push    = push && !full;
    do_pop     = pop && head_valid;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntOne;
      end else if (do_pop && !do_push) begin
        count <= count - CntOne;
      end
    end
  end

endmodule

// ===== rtl/core/b64se_back.sv =====
// back end: walks each group through four characters into the output register
module b64se_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  b64se_pkg::group_t   head_group,
  output logic                pop,
  output logic                char_valid,
  input  logic                char_stall,
  output b64se_pkg::out_item_t char_item
);
  import b64se_pkg::*;

  group_t     cur;
  logic       cur_valid;
  logic [1:0] k;
  logic       advance;
  logic       load;
  logic [5:0] sextet;
  logic [2:0] nchars;
  out_item_t  next_item;

  always_comb begin
    advance = cur_valid && (!char_valid || !char_stall);
    load    = !cur_valid || (advance && (k == LAST_CHAR));
    pop     = head_valid && load;
    nchars  = {1'b0, cur.held} + 3'd2;
    case (k)
      2'd0:    sextet = cur.word[23:18];
      2'd1:    sextet = cur.word[17:12];
      2'd2:    sextet = cur.word[11:6];
      default: sextet = cur.word[5:0];
    endcase
    next_item.out_char    = ({1'b0, k} < nchars) ? sextet_char(sextet) : PAD_CHAR;
    next_item.run_end     = (k == LAST_CHAR);
    next_item.message_end = (k == LAST_CHAR) && cur.fin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      k          <= 2'd0;
      char_valid <= 1'b0;
    end else begin
      if (advance) begin
        char_valid <= 1'b1;
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end
      if (load) begin
        cur_valid <= head_valid;
        k         <= 2'd0;
      end else if (advance) begin
        k <= k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_group;
    end
    if (advance) begin
      char_item <= next_item;
    end
  end

endmodule

// ===== rtl/core/base64_stream_encoder_core.sv =====
// top level of the base64 stream encoder core
// Base64 (standard alphabet, '=' padded) encoder for a byte stream. Bytes enter one
// per transfer with is_final on the last byte of a message; each completed group
// of three bytes, or a final group of one or two, leaves as four characters, one
// per transfer, with run_end on the fourth and message_end on the fourth of the
// final group. A byte is taken every cycle while the group queue has room; the
// output side delivers one character per cycle while char_stall is low, so a steady
// stream is limited by the single character output register. A group that closes
// passes through the group queue and the current-group register before its first
// character is written into the output register.
module base64_stream_encoder_core #(
  parameter int QueueDepth = b64se_pkg::B64SE_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  b64se_pkg::in_item_t  byte_item,
  output logic                 char_valid,
  input  logic                 char_stall,
  output b64se_pkg::out_item_t char_item
);
  import b64se_pkg::*;

  `include "base64_stream_encoder_core_macros.svh"

  logic   push;
  logic   queue_full;
  logic   pop;
  logic   head_valid;
  group_t push_group;
  group_t head_group;

  b64se_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .queue_full (queue_full),
    .push       (push),
    .group      (push_group)
  );

  b64se_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_group (push_group),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_group (head_group)
  );

  b64se_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_group (head_group),
    .pop        (pop),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item)
  );

  `B64SE_ASSERT(a_no_push_when_full, push |-> !queue_full, "group pushed into full queue")
  `B64SE_ASSERT(a_msg_end_on_run_end, char_valid && char_item.message_end |-> char_item.run_end, "message_end without run_end")
  `B64SE_ASSERT(a_pop_only_valid, pop |-> head_valid, "pop from empty queue")
  `B64SE_ASSERT_ALWAYS(a_reset_idle, rst |=> !char_valid, "output valid right after reset")

endmodule
